// ===== src/assert_macros.svh =====
// Assertion macros used by the blitter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies a consequence on the same edge.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/crb_pkg.sv =====
// Package with constants and helper functions of the clipped rectangle blitter.
package crb_pkg;
   localparam int SurfaceWidth  = 640;
   localparam int SurfaceHeight = 480;
   localparam int Depth = SurfaceWidth * SurfaceHeight;
   localparam int AddrWidth = $clog2(Depth);

   localparam logic [1:0] MODE_SOLID   = 2'd0;
   localparam logic [1:0] MODE_OUTLINE = 2'd1;
   localparam logic [1:0] MODE_BLEND   = 2'd2;
   localparam logic [1:0] MODE_READ    = 2'd3;

   localparam logic [1:0] FMT_8BPP = 2'd0;
   localparam logic [1:0] FMT_565  = 2'd1;
   localparam logic [1:0] FMT_555  = 2'd2;
   localparam logic [1:0] FMT_NONE = 2'd3;

   localparam logic [2:0] REG_MIN_X = 3'd0;
   localparam logic [2:0] REG_MAX_X = 3'd1;
   localparam logic [2:0] REG_MIN_Y = 3'd2;
   localparam logic [2:0] REG_MAX_Y = 3'd3;
   localparam logic [2:0] REG_FMT   = 3'd4;

   // Averages the color channels of a stored pixel and a fill color.
   function automatic logic [15:0] blend(input logic [15:0] p, input logic [15:0] c,
                                         input logic is555);
      logic [4:0] b;
      logic [5:0] g6;
      logic [5:0] r5;
      logic [6:0] gs;
      logic [15:0] res;
      b = 5'({1'b0, p[4:1]} + {1'b0, c[4:1]});
      if (is555) begin
         gs  = {2'b0, p[9:5]} + {2'b0, c[9:5]};
         r5  = {1'b0, p[14:10]} + {1'b0, c[14:10]};
         res = {1'b0, r5[5:1], gs[5:1], b};
      end else begin
         gs  = {1'b0, p[10:5]} + {1'b0, c[10:5]};
         g6  = gs[6:1];
         r5  = {1'b0, p[15:11]} + {1'b0, c[15:11]};
         res = {r5[5:1], g6[5:0], b};
      end
      return res;
   endfunction
endpackage

// ===== src/clipped_rect_blitter_unit.sv =====
// Top level of the clipped rectangle blitter with its frame store.
//
//  channel | direction | contents
//  req_    | in        | one drawing or read request
//  rsp_    | out       | read_data, clip_flags, drawn
//  csr_    | in/out    | clip window and pixel format registers
//
// A request is set up first, then each covered row is swept through the
// single-port frame store one pixel per cycle while no blend is pending;
// a blended pixel is read and written back in the next cycle, which holds
// the sweep. Reset is synchronous; the frame store is not cleared. A
// waiting response holds in its register and blocks new requests until it
// is taken.
`include "assert_macros.svh"
module clipped_rect_blitter_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], rect_left[17:2], rect_top[33:18], rect_right[49:34],
   // rect_bottom[65:50], offset_x[81:66], offset_y[97:82], fill_color[113:98],
   // pixel_x[123:114], pixel_y[133:124], zero fill to 136 bits
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_data[15:0], clip_flags[19:16], drawn[20], zero fill to 24 bits
   output logic [23:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int AW = crb_pkg::AddrWidth;

   typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_RUN, ST_BLEND_WR, ST_READ, ST_DONE}
      state_type;

   state_type   state_ff;
   logic [9:0]  min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [1:0]  fmt_ff;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   logic [1:0]  mode_ff;
   logic [15:0] color_ff;
   logic signed [18:0] l_ff, r_ff, t_ff, b_ff;   // clipped edges
   logic        lok_ff, rok_ff, tok_ff, bok_ff;
   logic signed [18:0] x_ff, y_ff;
   logic [3:0]  flags_ff;
   logic        drawn_ff;
   logic [15:0] rd_ff;

   logic [15:0] mem [crb_pkg::Depth];
   logic [15:0] mem_q_ff;

   // Configuration port.
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      case (csr_paddr[4:2])
         crb_pkg::REG_MIN_X: csr_prdata = {22'b0, min_x_ff};
         crb_pkg::REG_MAX_X: csr_prdata = {22'b0, max_x_ff};
         crb_pkg::REG_MIN_Y: csr_prdata = {22'b0, min_y_ff};
         crb_pkg::REG_MAX_Y: csr_prdata = {22'b0, max_y_ff};
         crb_pkg::REG_FMT:   csr_prdata = {30'b0, fmt_ff};
         default:            csr_prdata = 32'b0;
      endcase
   end

   // Request fields.
   logic [1:0] in_mode;
   logic signed [15:0] in_l, in_t, in_r, in_b, in_dx, in_dy;
   assign in_mode = req_tdata[1:0];
   assign in_l  = req_tdata[17:2];
   assign in_t  = req_tdata[33:18];
   assign in_r  = req_tdata[49:34];
   assign in_b  = req_tdata[65:50];
   assign in_dx = req_tdata[81:66];
   assign in_dy = req_tdata[97:82];

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !(rsp_valid_ff && !rsp_tready);
   assign accept = req_tvalid && req_tready;

   // Setup arithmetic on the registered raw rectangle.
   logic signed [18:0] ol, or_, ot, ob, cl, cr, ct, cb, sminx, smaxx, sminy, smaxy;
   logic [3:0] fl;
   logic empty_raw, outside, nonempty;
   logic signed [15:0] rl_ff, rt_ff, rr_ff, rb_ff, dx_ff, dy_ff;
   logic [9:0] px_ff, py_ff;
   always_comb begin
      empty_raw = (rr_ff <= rl_ff) || (rt_ff >= rb_ff);
      ol  = 19'(rl_ff) + 19'(dx_ff);
      or_ = 19'(rr_ff) + 19'(dx_ff);
      ot  = 19'(rt_ff) + 19'(dy_ff);
      ob  = 19'(rb_ff) + 19'(dy_ff);
      outside = (ol > 19'sd640) || (or_ < 0) || (ot > 19'sd480) || (ob < 0);
      sminx = 19'(min_x_ff); smaxx = 19'(max_x_ff);
      sminy = 19'(min_y_ff); smaxy = 19'(max_y_ff);
      cl = ol; cr = or_; ct = ot; cb = ob; fl = 4'b0;
      if (cl < sminx) begin cl = sminx; if (cr < sminx) cr = sminx - 19'sd1; fl[0] = 1'b1; end
      if (cr > smaxx) begin cr = smaxx; if (cl > smaxx) cl = smaxx + 19'sd1; fl[2] = 1'b1; end
      if (ct < sminy) begin ct = sminy; if (cb < sminy) cb = sminy - 19'sd1; fl[1] = 1'b1; end
      if (cb > smaxy) begin cb = smaxy; if (ct > smaxy) ct = smaxy + 19'sd1; fl[3] = 1'b1; end
      nonempty = (cl <= cr) && (ct <= cb);
   end

   // Sweep: is the current pixel to be touched, and where is the last one.
   logic on_edge_row, plot_now, in_surf, last_x, last_y;
   logic signed [18:0] x_end, x_next_run;
   logic [AW-1:0] addr;
   logic [15:0] wdata;
   always_comb begin
      on_edge_row = (mode_ff != crb_pkg::MODE_OUTLINE) || (y_ff == t_ff && tok_ff)
                    || (y_ff == b_ff && bok_ff);
      in_surf = (x_ff >= 0) && (x_ff < 19'sd640) && (y_ff >= 0) && (y_ff < 19'sd480);
      plot_now = on_edge_row || (x_ff == l_ff && lok_ff) || (x_ff == r_ff && rok_ff);
      x_end  = r_ff;
      last_x = (x_ff >= x_end);
      last_y = (y_ff >= b_ff);
      // Outline interior rows jump from left edge to right edge.
      x_next_run = (!on_edge_row && x_ff < r_ff) ? r_ff : x_ff + 19'sd1;
      addr = AW'(19'(y_ff[9:0]) * 19'sd640 + 19'(x_ff[9:0]));
      if (fmt_ff == crb_pkg::FMT_8BPP) wdata = {8'b0, color_ff[7:0]};
      else if (state_ff == ST_BLEND_WR)
         wdata = crb_pkg::blend(mem_q_ff, color_ff, fmt_ff == crb_pkg::FMT_555);
      else wdata = color_ff;
   end

   logic do_write, need_blend;
   assign need_blend = (mode_ff == crb_pkg::MODE_BLEND) && (fmt_ff != crb_pkg::FMT_8BPP);
   assign do_write = ((state_ff == ST_RUN && !need_blend) || state_ff == ST_BLEND_WR)
                     && plot_now && in_surf && fmt_ff != crb_pkg::FMT_NONE;

   logic [AW-1:0] rd_addr;
   assign rd_addr = AW'(20'(py_ff) * 20'd640 + 20'(px_ff));

   // Frame store, single port. The read data of a read request is held
   // while its response waits.
   always_ff @(posedge clock) begin
      if (do_write) mem[addr] <= wdata;
      if (state_ff == ST_READ) mem_q_ff <= mem[rd_addr];
      else if (state_ff != ST_DONE) mem_q_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_x_ff <= 10'd0;  max_x_ff <= 10'd639;
         min_y_ff <= 10'd0;  max_y_ff <= 10'd479;
         fmt_ff <= crb_pkg::FMT_565;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_paddr[4:2])
               crb_pkg::REG_MIN_X: min_x_ff <= csr_pwdata[9:0];
               crb_pkg::REG_MAX_X: max_x_ff <= csr_pwdata[9:0];
               crb_pkg::REG_MIN_Y: min_y_ff <= csr_pwdata[9:0];
               crb_pkg::REG_MAX_Y: max_y_ff <= csr_pwdata[9:0];
               crb_pkg::REG_FMT:   fmt_ff <= csr_pwdata[1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mode_ff <= in_mode;
                  rl_ff <= in_l; rt_ff <= in_t; rr_ff <= in_r; rb_ff <= in_b;
                  dx_ff <= in_dx; dy_ff <= in_dy;
                  color_ff <= req_tdata[113:98];
                  px_ff <= req_tdata[123:114];
                  py_ff <= req_tdata[133:124];
                  state_ff <= (in_mode == crb_pkg::MODE_READ) ? ST_READ : ST_SETUP;
               end
            end
            ST_READ: begin
               rd_ff <= (px_ff < 10'd640 && py_ff < 10'd480) ? 16'hffff : 16'h0;
               flags_ff <= 4'b0; drawn_ff <= 1'b0;
               state_ff <= ST_DONE;
            end
            ST_SETUP: begin
               rd_ff <= 16'h0;
               if (empty_raw || outside) begin
                  flags_ff <= 4'b0; drawn_ff <= 1'b0; state_ff <= ST_DONE;
               end else begin
                  flags_ff <= fl; drawn_ff <= nonempty;
                  lok_ff <= (ol == cl); rok_ff <= (or_ == cr);
                  tok_ff <= (ot == ct); bok_ff <= (ob == cb);
                  l_ff <= cl; r_ff <= cr; t_ff <= ct; b_ff <= cb;
                  x_ff <= cl; y_ff <= ct;
                  state_ff <= nonempty ? ST_RUN : ST_DONE;
               end
            end
            ST_RUN: begin
               if (need_blend && plot_now && in_surf) state_ff <= ST_BLEND_WR;
               else if (last_x) begin
                  if (last_y) state_ff <= ST_DONE;
                  else begin x_ff <= l_ff; y_ff <= y_ff + 19'sd1; end
               end else x_ff <= x_next_run;
            end
            ST_BLEND_WR: begin
               if (last_x) begin
                  if (last_y) state_ff <= ST_DONE;
                  else begin x_ff <= l_ff; y_ff <= y_ff + 19'sd1; state_ff <= ST_RUN; end
               end else begin x_ff <= x_ff + 19'sd1; state_ff <= ST_RUN; end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {3'b0, drawn_ff, flags_ff,
                                  (mode_ff == crb_pkg::MODE_READ) ? (rd_ff & mem_q_ff) : 16'h0};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A write only happens while sweeping a rectangle.
   `ASSERT_IMPLIES(a_wr_sweep, clock, reset, do_write,
                   state_ff == ST_RUN || state_ff == ST_BLEND_WR)
   // A blend write back is never followed directly by another blend write back.
   `ASSERT_NEXT(a_blend_seq, clock, reset, state_ff == ST_BLEND_WR, state_ff != ST_BLEND_WR)
   // No request is taken while the unit is busy with a request.
   `ASSERT_IMPLIES(a_no_accept, clock, reset, state_ff != ST_IDLE, !req_tready)
endmodule
